### rtl/pu_pkg.sv
// Package for the permutation unrank block: sizes, types and state codes.
`timescale 1ns / 1ps
package pu_pkg;

   localparam int MAX_N    = 18;
   localparam int VAL_W    = 5;
   localparam int RANK_W   = 53;
   localparam int CHUNK    = 8;
   localparam int CHUNKS   = (RANK_W + CHUNK - 1) / CHUNK;
   localparam int DIV_W    = CHUNKS * CHUNK;
   localparam int STEP_W   = $clog2(CHUNKS);
   localparam int REQ_W    = ((RANK_W + 7) / 8) * 8;
   localparam int RSP_W    = ((2 * VAL_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // digit from the divider into the cell row
   typedef struct packed {
      logic             push;
      logic [VAL_W-1:0] digit;
      logic             done;
   } digit_type;

   // control shared by every cell of the row
   typedef struct packed {
      logic             init;
      logic             push;
      logic             pop;
      logic [VAL_W-1:0] pick;
   } cell_ctrl_type;

endpackage

### rtl/pu_cell.sv
// One cell of the row: a digit slot and an unused-value slot with neighbor links.
`timescale 1ns / 1ps
module pu_cell (
   input  logic                           clock,
   input  pu_pkg::cell_ctrl_type          ctrl,
   input  logic [pu_pkg::VAL_W-1:0]       cell_index,
   input  logic [pu_pkg::VAL_W-1:0]       lower_digit,
   input  logic [pu_pkg::VAL_W-1:0]       upper_digit,
   input  logic [pu_pkg::VAL_W-1:0]       upper_value,
   output logic [pu_pkg::VAL_W-1:0]       digit,
   output logic [pu_pkg::VAL_W-1:0]       value
);

   logic [pu_pkg::VAL_W-1:0] digit_ff;
   logic [pu_pkg::VAL_W-1:0] digit_in;
   logic [pu_pkg::VAL_W-1:0] value_ff;
   logic [pu_pkg::VAL_W-1:0] value_in;

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.push) begin
         digit_in = lower_digit;
      end else if (ctrl.pop) begin
         digit_in = upper_digit;
      end
   end

   // removing the picked value closes the gap from above
   always_comb begin
      value_in = value_ff;
      if (ctrl.init) begin
         value_in = cell_index;
      end else if (ctrl.pop && (cell_index >= ctrl.pick)) begin
         value_in = upper_value;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
      value_ff <= value_in;
   end

   assign digit = digit_ff;
   assign value = value_ff;

endmodule

### rtl/pu_divider.sv
// Factorial-base digit unit: divides the rank by 1..n, eight quotient bits a cycle.
`timescale 1ns / 1ps
module pu_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [pu_pkg::RANK_W-1:0]     rank,
   input  logic [pu_pkg::VAL_W-1:0]      size,
   output pu_pkg::digit_type             dig
);

   logic                             busy_ff;
   logic                             busy_in;
   logic [pu_pkg::STEP_W-1:0]        step_ff;
   logic [pu_pkg::STEP_W-1:0]        step_in;
   logic [pu_pkg::VAL_W-1:0]         div_ff;
   logic [pu_pkg::VAL_W-1:0]         div_in;
   logic [pu_pkg::DIV_W-1:0]         quot_ff;
   logic [pu_pkg::DIV_W-1:0]         quot_in;
   logic [pu_pkg::VAL_W-1:0]         rem_ff;
   logic [pu_pkg::VAL_W-1:0]         rem_in;
   logic [pu_pkg::VAL_W-1:0]         rem_next;
   logic [pu_pkg::CHUNK-1:0]         qbits;
   logic                             chunk_end;

   // restoring division of the top byte, remainder stays below the divisor
   always_comb begin
      logic [pu_pkg::VAL_W:0] trial;
      logic [pu_pkg::VAL_W-1:0] r;
      r = rem_ff;
      qbits = '0;
      for (int k = 0; k < pu_pkg::CHUNK; k++) begin
         trial = {r, quot_ff[pu_pkg::DIV_W-1-k]};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
            qbits[pu_pkg::CHUNK-1-k] = 1'b1;
         end
         r = trial[pu_pkg::VAL_W-1:0];
      end
      rem_next = r;
   end

   assign chunk_end = busy_ff && (step_ff == pu_pkg::STEP_W'(pu_pkg::CHUNKS - 1));

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      div_in  = div_ff;
      if (load) begin
         busy_in = 1'b1;
         step_in = '0;
         div_in  = pu_pkg::VAL_W'(1);
      end else if (busy_ff) begin
         step_in = step_ff + pu_pkg::STEP_W'(1);
         if (chunk_end) begin
            step_in = '0;
            div_in  = div_ff + pu_pkg::VAL_W'(1);
            if (div_ff == size) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (load) begin
         quot_in = pu_pkg::DIV_W'(rank);
         rem_in  = '0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[pu_pkg::DIV_W-pu_pkg::CHUNK-1:0], qbits};
         rem_in  = chunk_end ? '0 : rem_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         div_ff  <= pu_pkg::VAL_W'(1);
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         div_ff  <= div_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign dig.push  = chunk_end;
   assign dig.digit = rem_next;
   assign dig.done  = chunk_end && (div_ff == size);

endmodule

### rtl/permutation_unrank_unit.sv
// Top level of the permutation unrank block: control, cell row and result register.
//
// Usage: a rank arrives as one transaction on the req_ channel (rank in
// req_tdata[52:0]). The block answers with n transactions on the rsp_
// channel, one per position in order: element in rsp_tdata[4:0], position
// in rsp_tdata[9:5], rsp_tlast high on the final one. n is the size
// register written through csr_wen / csr_wdata (0 acts as 1, above 18 as 18).
// Flow: after acceptance the digit unit divides the rank by 1..n, eight
// quotient bits a cycle over a 56-bit word; once the last digit is in the
// cell row the block enters its emit state and loads the first result, then one
// result per cycle while rsp_tready is high. One rank is handled at a time:
// a new rank is accepted only after the divider loop and the walk of the cell
// row, one pick per result, have ended with the final result loaded.
// A stalled receiver holds the result register and freezes the cell row; the
// next rank can be accepted while the final result still waits.
// Reset empties the result register, returns to idle and sets the size to 18.
`timescale 1ns / 1ps
module permutation_unrank_unit (
   input  logic                        clock,
   input  logic                        reset,
   // rank[52:0]
   input  logic [pu_pkg::REQ_W-1:0]    req_tdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // element[4:0], position[9:5]
   output logic [pu_pkg::RSP_W-1:0]    rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic                        csr_wen,
   input  logic [pu_pkg::VAL_W-1:0]    csr_wdata
);

   pu_pkg::state_type                state_ff;
   pu_pkg::state_type                state_in;
   logic [pu_pkg::VAL_W-1:0]         size_ff;
   logic [pu_pkg::VAL_W-1:0]         size_in;
   logic [pu_pkg::VAL_W-1:0]         n_eff;
   logic [pu_pkg::VAL_W-1:0]         pos_ff;
   logic [pu_pkg::VAL_W-1:0]         pos_in;
   logic                             out_valid_ff;
   logic                             out_valid_in;
   logic [pu_pkg::VAL_W-1:0]         out_element_ff;
   logic [pu_pkg::VAL_W-1:0]         out_position_ff;
   logic                             out_last_ff;
   logic                             accept;
   logic                             load_out;
   logic                             is_last;
   logic [pu_pkg::VAL_W-1:0]         picked;
   pu_pkg::digit_type                dig;
   pu_pkg::cell_ctrl_type            ctrl;
   logic [pu_pkg::VAL_W-1:0]         digit_w [pu_pkg::MAX_N];
   logic [pu_pkg::VAL_W-1:0]         value_w [pu_pkg::MAX_N];

   always_comb begin
      n_eff = size_ff;
      if (size_ff == '0) begin
         n_eff = pu_pkg::VAL_W'(1);
      end else if (size_ff > pu_pkg::VAL_W'(pu_pkg::MAX_N)) begin
         n_eff = pu_pkg::VAL_W'(pu_pkg::MAX_N);
      end
   end

   assign size_in = csr_wen ? csr_wdata : size_ff;

   pu_divider u_divider (
      .clock (clock),
      .reset (reset),
      .load  (accept),
      .rank  (req_tdata[pu_pkg::RANK_W-1:0]),
      .size  (n_eff),
      .dig   (dig)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pu_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = pu_pkg::ST_DIVIDE;
            end
         end
         pu_pkg::ST_DIVIDE: begin
            if (dig.done) begin
               state_in = pu_pkg::ST_EMIT;
            end
         end
         pu_pkg::ST_EMIT: begin
            if (load_out && is_last) begin
               state_in = pu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pu_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         pu_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         pu_pkg::ST_EMIT: begin
            load_out = !out_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign accept  = req_tvalid && req_tready;
   assign is_last = (pos_ff == (n_eff - pu_pkg::VAL_W'(1)));

   always_comb begin
      picked = '0;
      for (int i = 0; i < pu_pkg::MAX_N; i++) begin
         if (digit_w[0] == pu_pkg::VAL_W'(i)) begin
            picked = value_w[i];
         end
      end
   end

   assign ctrl.init = accept;
   assign ctrl.push = dig.push;
   assign ctrl.pop  = load_out;
   assign ctrl.pick = digit_w[0];

   genvar gi;
   generate
      for (gi = 0; gi < pu_pkg::MAX_N; gi++) begin : g_cell
         logic [pu_pkg::VAL_W-1:0] lower_digit;
         logic [pu_pkg::VAL_W-1:0] upper_digit;
         logic [pu_pkg::VAL_W-1:0] upper_value;

         if (gi == 0) begin : g_first
            assign lower_digit = dig.digit;
         end else begin : g_mid_low
            assign lower_digit = digit_w[gi-1];
         end

         if (gi == pu_pkg::MAX_N - 1) begin : g_last
            assign upper_digit = '0;
            assign upper_value = '0;
         end else begin : g_mid_up
            assign upper_digit = digit_w[gi+1];
            assign upper_value = value_w[gi+1];
         end

         pu_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .cell_index  (pu_pkg::VAL_W'(gi)),
            .lower_digit (lower_digit),
            .upper_digit (upper_digit),
            .upper_value (upper_value),
            .digit       (digit_w[gi]),
            .value       (value_w[gi])
         );
      end
   endgenerate

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = '0;
      end else if (load_out) begin
         pos_in = pos_ff + pu_pkg::VAL_W'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pu_pkg::ST_IDLE;
         size_ff      <= pu_pkg::VAL_W'(pu_pkg::MAX_N);
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_element_ff  <= picked;
         out_position_ff <= pos_ff;
         out_last_ff     <= is_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = pu_pkg::RSP_W'({out_position_ff, out_element_ff});
   assign rsp_tlast  = out_last_ff;

endmodule

### tb/sv/permutation_unrank_unit_tb.sv
// Self-checking testbench for the permutation unrank block: checks each result against a predictor.
`timescale 1ns / 1ps
module permutation_unrank_unit_tb;

   typedef struct {
      logic [pu_pkg::VAL_W-1:0] element;
      logic [pu_pkg::VAL_W-1:0] position;
      logic                     last;
   } perm_slot_type;

   localparam longint unsigned FACT_17 = 64'd355687428096000;
   localparam longint unsigned FACT_18 = 64'd6402373705728000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic [pu_pkg::REQ_W-1:0] req_tdata = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [pu_pkg::RSP_W-1:0] rsp_tdata;
   logic                     rsp_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic                     csr_wen = 1'b0;
   logic [pu_pkg::VAL_W-1:0] csr_wdata = '0;

   logic [pu_pkg::RANK_W-1:0] rank_q[$];
   perm_slot_type             perm_q[$];
   perm_slot_type             want;
   logic [pu_pkg::VAL_W-1:0]  size_cfg = 5'd18;
   int unsigned               tx_idle_pct = 0;
   int unsigned               rx_stall_pct = 0;
   int unsigned               rsp_hold_left = 0;
   int unsigned               mismatches = 0;

   permutation_unrank_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned eff_size(input logic [pu_pkg::VAL_W-1:0] size_reg);
      if (size_reg == 0) return 1;
      if (size_reg > pu_pkg::MAX_N) return pu_pkg::MAX_N;
      return 32'(size_reg);
   endfunction

   // factorial-base digits, then the d-th smallest unused value per position
   function automatic void unrank_rank(input logic [pu_pkg::RANK_W-1:0] rank,
                                       input logic [pu_pkg::VAL_W-1:0] size_reg);
      int unsigned              n;
      longint unsigned          r;
      int unsigned              digit[pu_pkg::MAX_N];
      logic [pu_pkg::MAX_N-1:0] taken;
      int unsigned              d;
      int unsigned              pick;
      perm_slot_type            slot;
      n = eff_size(size_reg);
      r = 64'(rank);
      taken = '0;
      for (int unsigned j = 1; j <= n; j++) begin
         digit[n-j] = 32'(r % j);
         r = r / j;
      end
      for (int unsigned j = 0; j < n; j++) begin
         d = digit[j];
         pick = 0;
         for (int unsigned v = 0; v < n; v++) begin
            if (!taken[v]) begin
               if (d == 0) begin
                  pick = v;
                  break;
               end
               d--;
            end
         end
         taken[pick] = 1'b1;
         slot.element = pick[pu_pkg::VAL_W-1:0];
         slot.position = j[pu_pkg::VAL_W-1:0];
         slot.last = (j + 1 == n);
         perm_q.push_back(slot);
      end
   endfunction

   function automatic logic [pu_pkg::RANK_W-1:0] random_rank();
      longint unsigned nfact;
      longint unsigned raw;
      int unsigned     n;
      n = eff_size(size_cfg);
      nfact = 1;
      for (int unsigned k = 2; k <= n; k++) nfact = nfact * k;
      raw = {$urandom, $urandom};
      case ($urandom_range(3))
         0: return raw[pu_pkg::RANK_W-1:0];
         1: return pu_pkg::RANK_W'(raw % nfact);
         2: return pu_pkg::RANK_W'(nfact - 1 - longint'($urandom_range(3)));
         default: return pu_pkg::RANK_W'($urandom_range(40));
      endcase
   endfunction

   // driver: offers queued ranks, predicts on each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) unrank_rank(req_tdata[pu_pkg::RANK_W-1:0], size_cfg);
         if (!req_tvalid || req_tready) begin
            if (rank_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= {{(pu_pkg::REQ_W-pu_pkg::RANK_W){1'b0}}, rank_q.pop_front()};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each accepted result transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (perm_q.size() == 0) begin
               $error("unexpected transaction: element %0d position %0d last %0b",
                      rsp_tdata[4:0], rsp_tdata[9:5], rsp_tlast);
               mismatches++;
            end else begin
               want = perm_q.pop_front();
               if (rsp_tdata[4:0] !== want.element) begin
                  $error("element: expected %0d, got %0d", want.element, rsp_tdata[4:0]);
                  mismatches++;
               end
               if (rsp_tdata[9:5] !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_tdata[9:5]);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
         rsp_tready <= (rsp_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (rsp_hold_left != 0) rsp_hold_left <= rsp_hold_left - 1;
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (rank_q.size() != 0 || req_tvalid || perm_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_size(input logic [pu_pkg::VAL_W-1:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      size_cfg = value;
      @(negedge clock);
   endtask

   task automatic queue_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) rank_q.push_back(random_rank());
   endtask

   initial begin
      logic [pu_pkg::VAL_W-1:0] phase_size[9];
      phase_size = '{5'd18, 5'd4, 5'd7, 5'd12, 5'd1, 5'd3, 5'd9, 5'd16, 5'd0};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, at the reset size of 18
      rank_q.push_back('0);
      rank_q.push_back(pu_pkg::RANK_W'(1));
      rank_q.push_back(pu_pkg::RANK_W'(FACT_18 - 1));
      rank_q.push_back(pu_pkg::RANK_W'(FACT_18));
      rank_q.push_back('1);
      rank_q.push_back(pu_pkg::RANK_W'(FACT_17));
      rank_q.push_back(pu_pkg::RANK_W'(FACT_17 - 1));
      rank_q.push_back(pu_pkg::RANK_W'({(pu_pkg::RANK_W+1)/2{2'b01}}));
      rank_q.push_back(pu_pkg::RANK_W'({(pu_pkg::RANK_W+1)/2{2'b10}}));
      rank_q.push_back(pu_pkg::RANK_W'(FACT_18 + 5));
      wait_idle();

      write_size(5'd1);
      rank_q.push_back('0);
      rank_q.push_back('1);
      wait_idle();

      // size zero behaves as one
      write_size(5'd0);
      rank_q.push_back(pu_pkg::RANK_W'(12345));
      wait_idle();

      // oversize saturates
      write_size(5'd31);
      rank_q.push_back('0);
      rank_q.push_back(pu_pkg::RANK_W'(FACT_18 - 1));
      wait_idle();

      write_size(5'd2);
      for (int unsigned i = 0; i < 4; i++) rank_q.push_back(pu_pkg::RANK_W'(i));
      wait_idle();

      // receiver holds off while the sender keeps offering
      write_size(5'd5);
      rsp_hold_left = 400;
      queue_random(10);
      wait_idle();

      phase_size[8] = pu_pkg::VAL_W'($urandom_range(1, pu_pkg::MAX_N));
      for (int unsigned p = 0; p < 9; p++) begin
         write_size(phase_size[p]);
         case (p % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
            default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
         endcase
         queue_random(15);
         // sender pause until the block has drained
         wait_idle();
         queue_random(12);
         wait_idle();
      end

      tx_idle_pct = 0;
      rx_stall_pct = 0;
      repeat (8 * pu_pkg::MAX_N + 20) @(negedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
